>>> sv/ctf_pkg.sv
// Shared types, constants and helper functions for the complementary tilt filter.
package ctf_pkg;

   localparam int CORDIC_STEPS_DEF    = 16;
   localparam int ANGLE_FRAC_BITS_DEF = 7;
   localparam int ATAN_LEN            = 24;

   localparam int CORDIC_W = 36;   // CORDIC x/y datapath
   localparam int ANG_W    = 27;   // degrees Q.16
   localparam int SQ_W     = 32;   // ay^2 + az^2
   localparam int ROOT_W   = 32;
   localparam int ADV_W    = 32;   // gyro advance, degrees Q.16
   localparam int GP_W     = 33;   // rate * dt
   localparam int MUL_A_W  = 18;
   localparam int MUL_B_W  = 34;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;
   localparam int ALPHA_W  = 17;
   localparam int DT_W     = 16;
   localparam int CSR_IDX_W = 1;

   localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'd65536;
   localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd64225;
   localparam logic [DT_W-1:0]    MAX_DT_RESET = 16'd1000;

   localparam logic [17:0] GYRO_DIV  = 18'd131000;  // 131 counts/dps * 1000 ms/s
   localparam logic [15:0] GYRO_HALF = 16'd65500;
   localparam logic [30:0] GYRO_RECIP = 31'd1074331972;  // floor(2^47 / 131000)
   localparam logic signed [ANG_W-1:0] DEG180 = 27'sd11796480;

   typedef enum logic [2:0] {
      S_IDLE, S_PREP, S_RUN1, S_RUN2, S_BLEND, S_DONE
   } state_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ALPHA       = 1'b0,
      CSR_MAX_ELAPSED = 1'b1
   } csr_idx_type;

   // atan(2^-i) in degrees Q.16, rounded to nearest
   function automatic logic [22:0] atan_q16(input logic [4:0] idx);
      logic [22:0] v;
      case (idx)
         5'd0:  v = 23'd2949120;
         5'd1:  v = 23'd1740967;
         5'd2:  v = 23'd919879;
         5'd3:  v = 23'd466945;
         5'd4:  v = 23'd234379;
         5'd5:  v = 23'd117304;
         5'd6:  v = 23'd58666;
         5'd7:  v = 23'd29335;
         5'd8:  v = 23'd14668;
         5'd9:  v = 23'd7334;
         5'd10: v = 23'd3667;
         5'd11: v = 23'd1833;
         5'd12: v = 23'd917;
         5'd13: v = 23'd458;
         5'd14: v = 23'd229;
         5'd15: v = 23'd115;
         5'd16: v = 23'd57;
         5'd17: v = 23'd29;
         5'd18: v = 23'd14;
         5'd19: v = 23'd7;
         5'd20: v = 23'd4;
         5'd21: v = 23'd2;
         5'd22: v = 23'd1;
         default: v = 23'd0;
      endcase
      return v;
   endfunction

   // round half up by sh bits, then saturate to 16 bits
   function automatic logic signed [15:0] round_sat(input logic signed [63:0] v,
                                                    input int unsigned sh);
      logic signed [63:0] t;
      t = (v + (64'sd1 <<< (sh - 1))) >>> sh;
      if (t > 64'sd32767) begin
         return 16'sh7fff;
      end else if (t < -64'sd32768) begin
         return 16'sh8000;
      end
      return t[15:0];
   endfunction

endpackage

>>> sv/ctf_ifs.sv
// Valid/ready channel interfaces for sensor samples and filtered angles.
interface ctf_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] accel_x;
   logic signed [15:0] accel_y;
   logic signed [15:0] accel_z;
   logic signed [15:0] gyro_x;
   logic signed [15:0] gyro_y;
   logic        [15:0] elapsed_ms;

   modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, elapsed_ms,
                   input ready);
   modport sink   (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, elapsed_ms,
                   output ready);
endinterface

interface ctf_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] pitch_angle;
   logic signed [15:0] roll_angle;
   logic               reseeded;

   modport source (output valid, pitch_angle, roll_angle, reseeded, input ready);
   modport sink   (input valid, pitch_angle, roll_angle, reseeded, output ready);
endinterface

>>> sv/ctf_isqrt.sv
// Digit-by-digit square root: floor(sqrt(v * 2^32)), one result bit per cycle.
module ctf_isqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [ctf_pkg::SQ_W-1:0]    v_in,
   output logic                        busy,
   output logic [ctf_pkg::ROOT_W-1:0]  root
);
   logic                       busy_ff;
   logic [4:0]                 cnt_ff;
   logic [31:0]                rad_ff;
   logic [35:0]                rem_ff;
   logic [ctf_pkg::ROOT_W-1:0] root_ff;
   logic [35:0]                rem_sh;
   logic [35:0]                trial;

   assign rem_sh = {rem_ff[33:0], rad_ff[31:30]};
   assign trial  = {2'b00, root_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= v_in;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff <= {rad_ff[29:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_ff  <= rem_sh - trial;
            root_ff <= {root_ff[30:0], 1'b1};
         end else begin
            rem_ff  <= rem_sh;
            root_ff <= {root_ff[30:0], 1'b0};
         end
      end
   end

   assign busy = busy_ff;
   assign root = root_ff;
endmodule

>>> sv/ctf_cdiv.sv
// Gyro advance |rate*dt|*2^16/131000 rounded to nearest: reciprocal multiply plus fix-up.
module ctf_cdiv (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic signed [ctf_pkg::GP_W-1:0]  p_in,
   output logic                             busy,
   output logic signed [ctf_pkg::ADV_W-1:0] quot
);
   localparam logic [19:0] DIV_ONE = {2'b00, ctf_pkg::GYRO_DIV};
   localparam logic [19:0] DIV_TWO = {1'b0, ctf_pkg::GYRO_DIV, 1'b0};

   logic        busy_ff;
   logic [1:0]  ph_ff;
   logic        neg_ff;
   logic [30:0] mag_ff;
   logic [30:0] q_ff;
   logic [19:0] rem_ff;
   logic [ctf_pkg::GP_W-1:0] mag;
   logic [61:0] est;
   logic [37:0] back;
   logic [19:0] num_lo;

   assign mag    = p_in[ctf_pkg::GP_W-1] ? -p_in : p_in;
   // estimate is never high and at most two low
   assign est    = mag_ff * ctf_pkg::GYRO_RECIP;
   // remainder fits in 20 bits, so only the low bits are formed
   assign back   = q_ff[19:0] * ctf_pkg::GYRO_DIV;
   assign num_lo = {mag_ff[3:0], ctf_pkg::GYRO_HALF};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         ph_ff   <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         ph_ff   <= '0;
      end else if (busy_ff) begin
         ph_ff <= ph_ff + 2'd1;
         if (ph_ff == 2'd2) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= p_in[ctf_pkg::GP_W-1];
         mag_ff <= mag[30:0];
      end else if (busy_ff) begin
         case (ph_ff)
            2'd0: q_ff <= est[61:31];
            2'd1: rem_ff <= num_lo - back[19:0];
            2'd2: begin
               if (rem_ff >= DIV_TWO) begin
                  q_ff <= q_ff + 31'd2;
               end else if (rem_ff >= DIV_ONE) begin
                  q_ff <= q_ff + 31'd1;
               end
            end
            default: ;
         endcase
      end
   end

   assign busy = busy_ff;
   assign quot = neg_ff ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});
endmodule

>>> sv/ctf_cordic.sv
// Vectoring CORDIC: atan2(y, x) in degrees Q.16, one micro-rotation per cycle.
module ctf_cordic #(
   parameter int STEPS = ctf_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [ctf_pkg::CORDIC_W-1:0] y_in,
   input  logic signed [ctf_pkg::CORDIC_W-1:0] x_in,
   output logic                                busy,
   output logic signed [ctf_pkg::ANG_W-1:0]    angle
);
   localparam int NSTEP = (STEPS > ctf_pkg::ATAN_LEN) ? ctf_pkg::ATAN_LEN : STEPS;
   localparam logic [4:0] LAST = 5'(NSTEP - 1);

   logic                                busy_ff;
   logic [4:0]                          cnt_ff;
   logic signed [ctf_pkg::CORDIC_W-1:0] x_ff, y_ff;
   logic signed [ctf_pkg::ANG_W-1:0]    z_ff;
   logic signed [ctf_pkg::CORDIC_W-1:0] xs, ys;
   logic signed [ctf_pkg::ANG_W-1:0]    da;

   assign xs = x_ff >>> cnt_ff;
   assign ys = y_ff >>> cnt_ff;
   assign da = $signed({{(ctf_pkg::ANG_W-23){1'b0}}, ctf_pkg::atan_q16(cnt_ff)});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= (y_in != '0);
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 5'd1;
         if (cnt_ff == LAST) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         if (y_in == '0) begin
            z_ff <= (x_in < 0) ? ctf_pkg::DEG180 : '0;
         end else if (x_in < 0) begin
            // fold into the right half plane
            x_ff <= -x_in;
            y_ff <= -y_in;
            z_ff <= (y_in > 0) ? ctf_pkg::DEG180 : -ctf_pkg::DEG180;
         end else begin
            x_ff <= x_in;
            y_ff <= y_in;
            z_ff <= '0;
         end
      end else if (busy_ff) begin
         if (y_ff > 0) begin
            x_ff <= x_ff + ys;
            y_ff <= y_ff - xs;
            z_ff <= z_ff + da;
         end else begin
            x_ff <= x_ff - ys;
            y_ff <= y_ff + xs;
            z_ff <= z_ff - da;
         end
      end
   end

   assign busy  = busy_ff;
   assign angle = z_ff;
endmodule

>>> sv/imu_complementary_tilt_filter.sv
// Top level of the complementary pitch/roll tilt filter.
//
//   channel  dir  handshake          payload
//   req_ch   in   valid/ready        accel_x/y/z, gyro_x/y, elapsed_ms
//   rsp_ch   out  valid/ready        pitch_angle, roll_angle, reseeded
//   csr_*    in   csr_we             csr_index, csr_wdata (17 bit)
//
// One transaction runs through accept, four multiply steps, the bit-serial root
// (roll CORDIC and the gyro divide run beside it), the pitch CORDIC, the blend and
// the result write. req_ch.ready is high only while idle.
// The result sits in an output register, so the next transaction is taken while it
// waits; a stalled rsp_ch holds the block in its last step until the slot frees.
// Reset is synchronous and clears the stored angles and the seeded flag.
module imu_complementary_tilt_filter #(
   parameter int CORDIC_STEPS    = ctf_pkg::CORDIC_STEPS_DEF,
   parameter int ANGLE_FRAC_BITS = ctf_pkg::ANGLE_FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   ctf_req_if.sink                         req_ch,
   ctf_rsp_if.source                       rsp_ch,
   input  logic                            csr_we,
   input  logic [ctf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ctf_pkg::ALPHA_W-1:0]     csr_wdata
);
   localparam int unsigned SH_Q16 = 16 - ANGLE_FRAC_BITS;
   localparam int unsigned SH_SUM = 32 - ANGLE_FRAC_BITS;
   localparam int CW = ctf_pkg::CORDIC_W;
   localparam int AW = ctf_pkg::ANG_W;
   localparam int BW = ctf_pkg::MUL_B_W;

   ctf_pkg::state_type state_ff, state_in;
   logic [2:0] step_ff;

   // config
   logic [ctf_pkg::ALPHA_W-1:0] alpha_ff;
   logic [ctf_pkg::DT_W-1:0]    max_dt_ff;

   // filter state
   logic signed [15:0] pitch_ff, roll_ff;
   logic               seeded_ff;

   // captured transaction
   logic signed [15:0] ax_ff, ay_ff, az_ff, gx_ff, gy_ff;
   logic [15:0]        dt_ff;
   logic               reseed_ff;

   // working values
   logic [ctf_pkg::SQ_W-1:0]          sq_ff;
   logic signed [ctf_pkg::PROD_W-1:0] prod_ff;
   logic signed [ctf_pkg::PROD_W-1:0] sum_p_ff, sum_r_ff;
   logic signed [AW-1:0]              acc_p_ff, acc_r_ff;
   logic signed [ctf_pkg::ADV_W-1:0]  adv_p_ff, adv_r_ff;

   // output slot
   logic               rsp_valid_ff;
   logic signed [15:0] rsp_pitch_ff, rsp_roll_ff;
   logic               rsp_reseed_ff;

   // shared units
   logic                      sqrt_start, cord_start, div_start;
   logic                      sqrt_busy, cord_busy, div_busy;
   logic [ctf_pkg::ROOT_W-1:0] root;
   logic signed [CW-1:0]      cord_y, cord_x;
   logic signed [AW-1:0]      cord_angle;
   logic signed [ctf_pkg::GP_W-1:0]  div_p;
   logic signed [ctf_pkg::ADV_W-1:0] div_q;

   logic                      units_idle, accept, out_free;
   logic [ctf_pkg::ALPHA_W-1:0] a_sat;
   logic signed [ctf_pkg::MUL_A_W-1:0] mul_a;
   logic signed [BW-1:0]      mul_b;
   logic signed [BW-1:0]      pred_p, pred_r;
   logic signed [15:0]        new_p, new_r;

   assign accept     = req_ch.valid && req_ch.ready;
   assign units_idle = !sqrt_busy && !cord_busy && !div_busy;
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign a_sat      = (alpha_ff > ctf_pkg::ALPHA_ONE) ? ctf_pkg::ALPHA_ONE : alpha_ff;

   // stored angle moved to Q.16 plus gyro advance
   assign pred_p = (BW'(pitch_ff) <<< SH_Q16) + BW'(adv_p_ff);
   assign pred_r = (BW'(roll_ff) <<< SH_Q16) + BW'(adv_r_ff);

   ctf_isqrt u_sqrt (
      .clock(clock), .reset(reset), .start(sqrt_start), .v_in(sq_ff),
      .busy(sqrt_busy), .root(root)
   );

   ctf_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clock(clock), .reset(reset), .start(cord_start), .y_in(cord_y), .x_in(cord_x),
      .busy(cord_busy), .angle(cord_angle)
   );

   ctf_cdiv u_div (
      .clock(clock), .reset(reset), .start(div_start), .p_in(div_p),
      .busy(div_busy), .quot(div_q)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ctf_pkg::S_IDLE:  if (accept) state_in = ctf_pkg::S_PREP;
         ctf_pkg::S_PREP:  if (step_ff == 3'd3) state_in = ctf_pkg::S_RUN1;
         ctf_pkg::S_RUN1:  if (units_idle) state_in = ctf_pkg::S_RUN2;
         ctf_pkg::S_RUN2:  if (units_idle) state_in = ctf_pkg::S_BLEND;
         ctf_pkg::S_BLEND: if (step_ff == 3'd4) state_in = ctf_pkg::S_DONE;
         ctf_pkg::S_DONE:  if (out_free) state_in = ctf_pkg::S_IDLE;
         default:          state_in = ctf_pkg::S_IDLE;
      endcase
   end

   // control outputs: unit starts and operand selection
   always_comb begin
      req_ch.ready = 1'b0;
      sqrt_start   = 1'b0;
      cord_start   = 1'b0;
      div_start    = 1'b0;
      cord_y       = CW'(ay_ff) <<< 16;   // roll: atan2(ay, az)
      cord_x       = CW'(az_ff) <<< 16;
      div_p        = prod_ff[ctf_pkg::GP_W-1:0];
      mul_a        = ctf_pkg::MUL_A_W'(ay_ff);
      mul_b        = BW'(ay_ff);
      unique case (state_ff)
         ctf_pkg::S_IDLE: req_ch.ready = 1'b1;
         ctf_pkg::S_PREP: begin
            case (step_ff)
               3'd1: begin
                  mul_a = ctf_pkg::MUL_A_W'(az_ff);
                  mul_b = BW'(az_ff);
               end
               3'd2: begin
                  mul_a = ctf_pkg::MUL_A_W'(gy_ff);
                  mul_b = BW'({1'b0, dt_ff});
               end
               3'd3: begin
                  mul_a = ctf_pkg::MUL_A_W'(gx_ff);
                  mul_b = BW'({1'b0, dt_ff});
                  // sum of squares and gy*dt are ready: launch phase one
                  sqrt_start = 1'b1;
                  cord_start = 1'b1;
                  div_start  = 1'b1;
               end
               default: ;
            endcase
         end
         ctf_pkg::S_RUN1: begin
            // pitch: atan2(-ax, root); prod_ff still holds gx*dt
            cord_y     = -(CW'(ax_ff) <<< 16);
            cord_x     = CW'({1'b0, root});
            cord_start = units_idle;
            div_start  = units_idle;
         end
         ctf_pkg::S_RUN2: ;
         ctf_pkg::S_BLEND: begin
            case (step_ff)
               3'd0: begin
                  mul_a = ctf_pkg::MUL_A_W'({1'b0, a_sat});
                  mul_b = pred_p;
               end
               3'd1: begin
                  mul_a = ctf_pkg::MUL_A_W'({1'b0, ctf_pkg::ALPHA_ONE - a_sat});
                  mul_b = BW'(acc_p_ff);
               end
               3'd2: begin
                  mul_a = ctf_pkg::MUL_A_W'({1'b0, a_sat});
                  mul_b = pred_r;
               end
               3'd3: begin
                  mul_a = ctf_pkg::MUL_A_W'({1'b0, ctf_pkg::ALPHA_ONE - a_sat});
                  mul_b = BW'(acc_r_ff);
               end
               default: ;
            endcase
         end
         ctf_pkg::S_DONE: ;
         default: ;
      endcase
   end

   // final angles: reseed straight from the accelerometer, else the blended sum
   always_comb begin
      if (reseed_ff) begin
         new_p = ctf_pkg::round_sat(64'(acc_p_ff), SH_Q16);
         new_r = ctf_pkg::round_sat(64'(acc_r_ff), SH_Q16);
      end else begin
         new_p = ctf_pkg::round_sat(64'(sum_p_ff), SH_SUM);
         new_r = ctf_pkg::round_sat(64'(sum_r_ff), SH_SUM);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ctf_pkg::S_IDLE;
         step_ff      <= '0;
         alpha_ff     <= ctf_pkg::ALPHA_RESET;
         max_dt_ff    <= ctf_pkg::MAX_DT_RESET;
         pitch_ff     <= '0;
         roll_ff      <= '0;
         seeded_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= (state_in != state_ff) ? 3'd0 : step_ff + 3'd1;
         if (csr_we) begin
            unique case (ctf_pkg::csr_idx_type'(csr_index))
               ctf_pkg::CSR_ALPHA:       alpha_ff  <= csr_wdata;
               ctf_pkg::CSR_MAX_ELAPSED: max_dt_ff <= csr_wdata[ctf_pkg::DT_W-1:0];
            endcase
         end
         if (state_ff == ctf_pkg::S_DONE && out_free) begin
            pitch_ff     <= new_p;
            roll_ff      <= new_r;
            seeded_ff    <= 1'b1;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         ax_ff     <= req_ch.accel_x;
         ay_ff     <= req_ch.accel_y;
         az_ff     <= req_ch.accel_z;
         gx_ff     <= req_ch.gyro_x;
         gy_ff     <= req_ch.gyro_y;
         dt_ff     <= req_ch.elapsed_ms;
         reseed_ff <= !seeded_ff || (req_ch.elapsed_ms == '0) ||
                      (req_ch.elapsed_ms > max_dt_ff);
      end
      if (state_ff == ctf_pkg::S_PREP || state_ff == ctf_pkg::S_BLEND) begin
         prod_ff <= mul_a * mul_b;
      end
      if (state_ff == ctf_pkg::S_PREP) begin
         if (step_ff == 3'd1) sq_ff <= prod_ff[ctf_pkg::SQ_W-1:0];
         if (step_ff == 3'd2) sq_ff <= sq_ff + prod_ff[ctf_pkg::SQ_W-1:0];
      end
      if (state_ff == ctf_pkg::S_RUN1 && units_idle) begin
         acc_r_ff <= cord_angle;
         adv_p_ff <= div_q;
      end
      if (state_ff == ctf_pkg::S_RUN2 && units_idle) begin
         acc_p_ff <= cord_angle;
         adv_r_ff <= div_q;
      end
      if (state_ff == ctf_pkg::S_BLEND) begin
         case (step_ff)
            3'd1: sum_p_ff <= prod_ff;
            3'd2: sum_p_ff <= sum_p_ff + prod_ff;
            3'd3: sum_r_ff <= prod_ff;
            3'd4: sum_r_ff <= sum_r_ff + prod_ff;
            default: ;
         endcase
      end
      if (state_ff == ctf_pkg::S_DONE && out_free) begin
         rsp_pitch_ff  <= new_p;
         rsp_roll_ff   <= new_r;
         rsp_reseed_ff <= reseed_ff;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.pitch_angle = rsp_pitch_ff;
   assign rsp_ch.roll_angle  = rsp_roll_ff;
   assign rsp_ch.reseeded    = rsp_reseed_ff;
endmodule

>>> sv/ctf_checker.sv
// Port-level checks for the tilt filter, bound to the top level.
module ctf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_pitch,
   input logic [15:0] rsp_roll,
   input logic        rsp_reseed
);
   // after reset the block is idle with an empty output slot
   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("not idle after reset");

   // one transaction at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready stayed high after accept");

   // a result needs many cycles of work
   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result appeared right after accept");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_pitch) && $stable(rsp_roll) && $stable(rsp_reseed))
      else $error("stalled result changed");
endmodule

bind imu_complementary_tilt_filter ctf_checker u_ctf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_pitch  (rsp_ch.pitch_angle),
   .rsp_roll   (rsp_ch.roll_angle),
   .rsp_reseed (rsp_ch.reseeded)
);
